>>> rtl/cnff_pkg.sv
`timescale 1ns / 1ps
// Shared types, codes and stop-bit tables for the cassette nibble frame encoder.
// Used by cnff_front, cnff_queue, cnff_back and the top level; depends on nothing.
package cnff_pkg;

	// Sync word length and frame geometry
	localparam int SYNC_BITS = 32;
	localparam int NIB_PART  = 5;
	localparam int FRAME_MAX = 22;
	localparam int RUN_MAX   = (SYNC_BITS > FRAME_MAX) ? SYNC_BITS : FRAME_MAX;
	localparam int POS_W     = $clog2(RUN_MAX);
	localparam int STOP_W    = 3;

	// Register reset values
	localparam logic [7:0]  BLOCK_LENGTH_RST = 8'd120;
	localparam logic [15:0] TONE_ZERO_RST    = 16'hCCCC;
	localparam logic [15:0] TONE_ONE_RST     = 16'hAAAA;

	// Mode used for an explicit sum request
	localparam logic [3:0] MODE_SUM = 4'd8;

	typedef enum logic [1:0] {
		CFG_BLOCK_LENGTH = 2'd0,
		CFG_TONE_ZERO    = 2'd1,
		CFG_TONE_ONE     = 2'd2,
		CFG_NONE         = 2'd3
	} cfg_idx_t;

	typedef enum logic [1:0] {
		FUNC_DATA  = 2'd0,
		FUNC_SYNC  = 2'd1,
		FUNC_SUM   = 2'd2,
		FUNC_CLEAR = 2'd3
	} func_t;

	typedef enum logic {
		JOB_FRAME = 1'b0,
		JOB_SYNC  = 1'b1
	} job_kind_t;

	// One classified transaction waiting for the serialiser
	typedef struct packed {
		job_kind_t         kind;
		logic [STOP_W-1:0] stop_hi;
		logic [STOP_W-1:0] stop_lo;
		logic [7:0]        data;
		logic              sum_pend;
		logic [7:0]        sum_data;
	} job_t;

	// Stop ones after the high nibble; modes beyond the table act as mode 8
	function automatic logic [STOP_W-1:0] stop_hi_of(input logic [3:0] mode);
		logic [STOP_W-1:0] r;
		unique case (mode)
			4'd0: r = 3'd6;
			4'd1: r = 3'd5;
			4'd2: r = 3'd5;
			4'd3: r = 3'd4;
			default: r = 3'd1;
		endcase
		return r;
	endfunction

	// Stop ones after the low nibble
	function automatic logic [STOP_W-1:0] stop_lo_of(input logic [3:0] mode);
		logic [STOP_W-1:0] r;
		unique case (mode)
			4'd0: r = 3'd6;
			4'd1: r = 3'd6;
			4'd2: r = 3'd5;
			4'd3: r = 3'd5;
			4'd4: r = 3'd6;
			4'd5: r = 3'd5;
			4'd6: r = 3'd4;
			4'd7: r = 3'd3;
			default: r = 3'd2;
		endcase
		return r;
	endfunction

endpackage

>>> rtl/cassette_nibble_frame_fsk_encoder_unit.sv
`timescale 1ns / 1ps
// Cassette nibble frame encoder, top level.
// Input channel (in_valid / in_stall) takes one command per transaction: a data
// byte to frame, a 32-one sync word, a request to send the running sum, or a
// clear of the sum. Output channel (out_valid / out_stall) gives one line bit
// per transaction, high nibble first, bits of a nibble least significant first,
// with its tone word; last_of_run marks the final bit caused by a command.
// A data byte gives 13 to 22 bits (twice that when it closes a block and the sum
// frame follows), a sync word 32 bits, a sum request 13 bits, a clear nothing.
// A command passes the job queue, the serialiser's job register and the output
// register before its first bit; the single serialiser then sends one bit per
// cycle unless the receiver stalls. A two-entry job queue lets commands be
// taken while earlier ones are being serialised, so commands stream with no gap.
// Reset clears the sum, block count, queue and output, and loads the register
// defaults (block length 120, tones 0xCCCC and 0xAAAA). When the receiver
// stalls, the output register holds; once the queue fills, in_stall rises.
// The user must write configuration (cfg_we, cfg_index, cfg_data) only while
// idle; the block does not enforce it. Depends on cnff_pkg, cnff_front, cnff_queue, cnff_back.
module cassette_nibble_frame_fsk_encoder_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [15:0] cfg_data,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  func,
	input  logic [3:0]  mode,
	input  logic [7:0]  data_byte,
	input  logic        add_to_checksum,
	output logic        out_valid,
	input  logic        out_stall,
	output logic        line_bit,
	output logic [15:0] tone_word,
	output logic        last_of_run
);

	logic [7:0]     block_length_q;
	logic [15:0]    tone_zero_q;
	logic [15:0]    tone_one_q;
	logic           push;
	cnff_pkg::job_t push_job;
	logic           q_full;
	logic           pop;
	logic           head_valid;
	cnff_pkg::job_t head_job;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			block_length_q <= cnff_pkg::BLOCK_LENGTH_RST;
			tone_zero_q    <= cnff_pkg::TONE_ZERO_RST;
			tone_one_q     <= cnff_pkg::TONE_ONE_RST;
		end else if (cfg_we) begin
			unique case (cnff_pkg::cfg_idx_t'(cfg_index))
				cnff_pkg::CFG_BLOCK_LENGTH: block_length_q <= cfg_data[7:0];
				cnff_pkg::CFG_TONE_ZERO:    tone_zero_q    <= cfg_data;
				cnff_pkg::CFG_TONE_ONE:     tone_one_q     <= cfg_data;
				cnff_pkg::CFG_NONE: begin
				end
				default: begin
				end
			endcase
		end
	end

	cnff_front u_front (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.func           (func),
		.mode           (mode),
		.data_byte      (data_byte),
		.add_to_checksum(add_to_checksum),
		.block_length   (block_length_q),
		.q_full         (q_full),
		.in_stall       (in_stall),
		.push           (push),
		.push_job       (push_job)
	);

	cnff_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_job  (push_job),
		.pop       (pop),
		.full      (q_full),
		.head_valid(head_valid),
		.head_job  (head_job)
	);

	cnff_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (head_valid),
		.head_job   (head_job),
		.tone_zero  (tone_zero_q),
		.tone_one   (tone_one_q),
		.out_stall  (out_stall),
		.pop        (pop),
		.out_valid  (out_valid),
		.line_bit   (line_bit),
		.tone_word  (tone_word),
		.last_of_run(last_of_run)
	);

endmodule

>>> rtl/cnff_front.sv
`timescale 1ns / 1ps
// Front end: accepts input transactions, keeps the running sum and block count
// and turns each transaction but a clear into a serialiser job. Depends on cnff_pkg.
module cnff_front (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	input  logic [1:0]          func,
	input  logic [3:0]          mode,
	input  logic [7:0]          data_byte,
	input  logic                add_to_checksum,
	input  logic [7:0]          block_length,
	input  logic                q_full,
	output logic                in_stall,
	output logic                push,
	output cnff_pkg::job_t      push_job
);

	logic [7:0] sum_q;
	logic [7:0] count_q;
	logic       accept;
	logic [8:0] sum_hi;
	logic [7:0] sum_adj;
	logic [7:0] sum_new;
	logic [7:0] count_new;
	logic       blk_done;

	assign in_stall = q_full;
	assign accept   = in_valid && !q_full;

	// High nibble with end-around carry, then low nibble with wrap
	always_comb begin
		sum_hi    = {1'b0, sum_q} + 9'(data_byte[7:4]);
		sum_adj   = sum_hi[8] ? (sum_hi[7:0] + 8'd1) : sum_hi[7:0];
		sum_new   = sum_adj + 8'(data_byte[3:0]);
		count_new = count_q + 8'd1;
		blk_done  = (count_new >= block_length);
	end

	// Classify the transaction into a job
	always_comb begin
		push_job          = '0;
		push_job.kind     = cnff_pkg::JOB_FRAME;
		push_job.stop_hi  = cnff_pkg::stop_hi_of(mode);
		push_job.stop_lo  = cnff_pkg::stop_lo_of(mode);
		push_job.data     = data_byte;
		push_job.sum_pend = add_to_checksum && blk_done;
		push_job.sum_data = sum_new;
		push              = 1'b0;
		unique case (cnff_pkg::func_t'(func))
			cnff_pkg::FUNC_DATA: begin
				push = accept;
			end
			cnff_pkg::FUNC_SYNC: begin
				push          = accept;
				push_job.kind = cnff_pkg::JOB_SYNC;
			end
			cnff_pkg::FUNC_SUM: begin
				push              = accept;
				push_job.stop_hi  = cnff_pkg::stop_hi_of(cnff_pkg::MODE_SUM);
				push_job.stop_lo  = cnff_pkg::stop_lo_of(cnff_pkg::MODE_SUM);
				push_job.data     = sum_q;
				push_job.sum_pend = 1'b0;
			end
			cnff_pkg::FUNC_CLEAR: begin
				push = 1'b0;
			end
			default: begin
				push = 1'b0;
			end
		endcase
	end

	// Update the running sum and block count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q   <= '0;
			count_q <= '0;
		end else if (accept) begin
			if (func == cnff_pkg::FUNC_CLEAR) begin
				sum_q   <= '0;
				count_q <= '0;
			end else if (func == cnff_pkg::FUNC_DATA && add_to_checksum) begin
				if (blk_done) begin
					sum_q   <= '0;
					count_q <= '0;
				end else begin
					sum_q   <= sum_new;
					count_q <= count_new;
				end
			end
		end
	end

endmodule

>>> rtl/cnff_queue.sv
`timescale 1ns / 1ps
// Two-entry job queue between the front end and the serialiser.
// Depends on cnff_pkg for the job type.
module cnff_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  cnff_pkg::job_t push_job,
	input  logic           pop,
	output logic           full,
	output logic           head_valid,
	output cnff_pkg::job_t head_job
);

	cnff_pkg::job_t mem_q [2];
	logic           wr_ptr_q;
	logic           rd_ptr_q;
	logic [1:0]     count_q;

	assign full       = (count_q == 2'd2);
	assign head_valid = (count_q != 2'd0);
	assign head_job   = mem_q[rd_ptr_q];

	// Store incoming jobs
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_job;
		end
	end

	// Advance pointers and occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			if (push && !pop) begin
				count_q <= count_q + 2'd1;
			end else if (pop && !push) begin
				count_q <= count_q - 2'd1;
			end
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		!(push && full))
		else $error("job queue overflow");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		!(pop && !head_valid))
		else $error("job queue underflow");

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q != 2'd3)
		else $error("job queue count out of range");

	a_ptr_match: assert property (@(posedge clk) disable iff (!arst_n)
		(count_q == 2'd1) |-> (wr_ptr_q != rd_ptr_q))
		else $error("job queue pointers disagree with count");

endmodule

>>> rtl/cnff_back.sv
`timescale 1ns / 1ps
// Serialiser: walks the current job, one line bit per cycle unless stalled,
// into an output register with its tone word. Depends on cnff_pkg.
module cnff_back (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           head_valid,
	input  cnff_pkg::job_t head_job,
	input  logic [15:0]    tone_zero,
	input  logic [15:0]    tone_one,
	input  logic           out_stall,
	output logic           pop,
	output logic           out_valid,
	output logic           line_bit,
	output logic [15:0]    tone_word,
	output logic           last_of_run
);

	localparam int PW = cnff_pkg::POS_W;

	cnff_pkg::job_t job_q;
	logic           busy_q;
	logic           second_q;
	logic [PW-1:0]  pos_q;
	logic           out_valid_q;
	logic           line_bit_q;
	logic [15:0]    tone_q;
	logic           last_q;

	logic           adv;
	logic [PW-1:0]  p1;
	logic [PW-1:0]  run_len;
	logic [PW-1:0]  q;
	logic [7:0]     cur_byte;
	logic [3:0]     nib;
	logic [1:0]     nib_idx;
	logic           bit_now;
	logic           end_bit;
	logic           go_second;
	logic           last_now;

	assign adv = !out_valid_q || !out_stall;

	// Work out the bit at the current position
	always_comb begin
		p1       = PW'(cnff_pkg::NIB_PART) + PW'(job_q.stop_hi);
		cur_byte = second_q ? job_q.sum_data : job_q.data;
		if (pos_q < p1) begin
			q   = pos_q;
			nib = cur_byte[7:4];
		end else begin
			q   = pos_q - p1;
			nib = cur_byte[3:0];
		end
		nib_idx = 2'(q - PW'(1));
		if (job_q.kind == cnff_pkg::JOB_SYNC) begin
			run_len = PW'(cnff_pkg::SYNC_BITS);
			bit_now = 1'b1;
		end else begin
			run_len = p1 + PW'(cnff_pkg::NIB_PART) + PW'(job_q.stop_lo);
			if (q == '0) begin
				bit_now = 1'b0;
			end else if (q <= PW'(4)) begin
				bit_now = nib[nib_idx];
			end else begin
				bit_now = 1'b1;
			end
		end
		end_bit   = (pos_q == run_len - PW'(1));
		go_second = (job_q.kind == cnff_pkg::JOB_FRAME) && !second_q && job_q.sum_pend;
		last_now  = end_bit && !go_second;
	end

	// Take the next job when idle or as the current one finishes
	assign pop = head_valid && (!busy_q || (adv && last_now));

	// Walk the current job
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q   <= 1'b0;
			second_q <= 1'b0;
			pos_q    <= '0;
		end else if (pop) begin
			busy_q   <= 1'b1;
			second_q <= 1'b0;
			pos_q    <= '0;
		end else if (busy_q && adv) begin
			if (end_bit && go_second) begin
				second_q <= 1'b1;
				pos_q    <= '0;
			end else if (end_bit) begin
				busy_q <= 1'b0;
			end else begin
				pos_q <= pos_q + PW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			job_q <= head_job;
		end
	end

	// Output register: hold while stalled
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= busy_q;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && busy_q) begin
			line_bit_q <= bit_now;
			tone_q     <= bit_now ? tone_one : tone_zero;
			last_q     <= last_now;
		end
	end

	assign out_valid   = out_valid_q;
	assign line_bit    = line_bit_q;
	assign tone_word   = tone_q;
	assign last_of_run = last_q;

endmodule
